// ===== rtl/car_pkg.sv =====
// Package with the shared types, codes and constants of the cumulative-ACK receiver.
`default_nettype none

package car_pkg;

    localparam int CAR_MAX_PAYLOAD   = 1016;
    localparam int CAR_QUEUE_DEPTH   = 4;
    localparam logic [15:0] CAR_TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_REQ     = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic REQ_TYPE_PKT  = 1'b0;
    localparam logic REQ_TYPE_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_RECV  = 2'd0,
        MODE_FINAL = 2'd1,
        MODE_DONE  = 2'd2
    } mode_t;

    // One command covers every result that one input word causes.
    typedef enum logic [2:0] {
        CMD_REQ      = 3'd0,
        CMD_ACK      = 3'd1,
        CMD_ACK_FIN  = 3'd2,
        CMD_DATA     = 3'd3,
        CMD_DATA_FIN = 3'd4,
        CMD_DONE     = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  pkt_req;
        logic [7:0]  pkt_fin;
        logic [9:0]  pkt_len;
        logic [31:0] pkt_seq;
        logic        pkt_corrupt;
    } car_in_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [31:0] ack_seq;
        logic        ack_fin;
        logic [9:0]  deliver_len;
        logic        last;
    } car_out_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] seq;
        logic [9:0]  len;
    } car_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/car_front.sv =====
// Front end: accepts input words, keeps the protocol state and issues commands.
`default_nettype none

module car_front #(
    parameter int MAX_PAYLOAD = car_pkg::CAR_MAX_PAYLOAD
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_wdata,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire car_pkg::car_in_t in_word,
    input  wire logic             q_full,
    output logic                  push,
    output car_pkg::car_cmd_t     push_cmd
);
    import car_pkg::*;

    localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);

    mode_t       mode_reg, mode_next;
    logic [31:0] exp_reg, exp_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] timeout_reg;

    logic        accept;
    logic [15:0] tick_inc;
    logic [15:0] limit;
    logic [9:0]  len_clamped;
    logic [31:0] exp_adv;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign tick_inc = tick_reg + 16'd1;
    assign limit    = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign len_clamped = ({6'd0, in_word.pkt_len} > MAX_LEN16) ? MAX_LEN16[9:0]
                                                               : in_word.pkt_len;
    assign exp_adv  = exp_reg + {22'd0, len_clamped};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= CAR_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RECV;
            exp_reg  <= 32'd0;
            tick_reg <= 16'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            exp_reg  <= exp_next;
            tick_reg <= tick_next;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        exp_next      = exp_reg;
        tick_next     = tick_reg;
        push          = 1'b0;
        push_cmd.kind = CMD_ACK;
        push_cmd.seq  = exp_reg;
        push_cmd.len  = 10'd0;
        if (accept && (mode_reg == MODE_RECV || mode_reg == MODE_FINAL))
        begin
            if (in_word.req_type == REQ_TYPE_TICK)
            begin
                if (tick_inc < limit)
                begin
                    tick_next = tick_inc;
                end
                else
                begin
                    tick_next = 16'd0;
                    push      = 1'b1;
                    if (exp_reg == 32'd0)
                    begin
                        push_cmd.kind = CMD_REQ;
                        push_cmd.seq  = 32'd0;
                    end
                    else if (mode_reg == MODE_FINAL)
                    begin
                        push_cmd.kind = CMD_ACK_FIN;
                    end
                end
            end
            else if (!in_word.pkt_corrupt)
            begin
                if (mode_reg == MODE_FINAL)
                begin
                    if (in_word.pkt_req == 8'd1)
                    begin
                        mode_next     = MODE_DONE;
                        push          = 1'b1;
                        push_cmd.kind = CMD_DONE;
                        push_cmd.seq  = 32'd0;
                    end
                end
                else if (in_word.pkt_seq > exp_reg)
                begin
                    tick_next = 16'd0;
                    push      = 1'b1;
                end
                else if (in_word.pkt_seq == exp_reg)
                begin
                    tick_next     = 16'd0;
                    exp_next      = exp_adv;
                    push          = 1'b1;
                    push_cmd.seq  = exp_adv;
                    push_cmd.len  = len_clamped;
                    if (in_word.pkt_fin == 8'd1)
                    begin
                        push_cmd.kind = CMD_DATA_FIN;
                        mode_next     = MODE_FINAL;
                    end
                    else
                    begin
                        push_cmd.kind = CMD_DATA;
                    end
                end
            end
        end
    end

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("command issued without an accepted word");
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DONE) |=> (mode_reg == MODE_DONE))
        else $error("left done mode");
    a_no_return_recv: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_RECV) |=> (mode_reg != MODE_RECV))
        else $error("returned to receiving mode");

endmodule

`default_nettype wire

// ===== rtl/car_queue.sv =====
// Short command queue between the front end and the result sequencer.
`default_nettype none

module car_queue #(
    parameter int DEPTH = car_pkg::CAR_QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire car_pkg::car_cmd_t push_cmd,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output car_pkg::car_cmd_t      head
);
    import car_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    car_cmd_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_ONE))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/car_back.sv =====
// Back end: expands each queued command into result words, one per cycle while out_ready does not stall the output.
`default_nettype none

module car_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire car_pkg::car_cmd_t head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output car_pkg::car_out_t      out_word
);
    import car_pkg::*;

    logic       out_valid_reg;
    car_out_t   out_reg;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    car_out_t   res;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign load      = (!out_valid_reg || out_ready) && !empty;
    assign pop       = load && res.last;

    always_comb
    begin
        res.out_kind    = KIND_ACK;
        res.ack_seq     = head.seq;
        res.ack_fin     = 1'b0;
        res.deliver_len = 10'd0;
        res.last        = 1'b1;
        unique case (head.kind)
            CMD_REQ:
            begin
                res.out_kind = KIND_REQ;
                res.ack_seq  = 32'd0;
            end
            CMD_ACK:
            begin
            end
            CMD_ACK_FIN:
            begin
                res.ack_fin = (idx_reg != 2'd0);
                res.last    = (idx_reg != 2'd0);
            end
            CMD_DATA, CMD_DATA_FIN:
            begin
                if (idx_reg == 2'd0)
                begin
                    res.out_kind    = KIND_DELIVER;
                    res.ack_seq     = 32'd0;
                    res.deliver_len = head.len;
                    res.last        = 1'b0;
                end
                else if (idx_reg == 2'd1)
                begin
                    res.last = (head.kind == CMD_DATA);
                end
                else
                begin
                    res.ack_fin = 1'b1;
                end
            end
            CMD_DONE:
            begin
                res.out_kind = KIND_DONE;
                res.ack_seq  = 32'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = res.last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= !empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    a_deliver_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.out_kind == KIND_DELIVER) |-> !out_reg.last)
        else $error("deliver word marked last");
    a_fin_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ack_fin) |-> out_reg.last)
        else $error("FIN-ACK not the final word");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> (head.kind == CMD_ACK_FIN || head.kind == CMD_DATA
                               || head.kind == CMD_DATA_FIN) && !empty)
        else $error("result index active on a single-word command");

endmodule

`default_nettype wire

// ===== rtl/cumulative_ack_receiver_core.sv =====
// Top level of the cumulative-ACK receiver: front end, command queue and back end.
//
// Input channel in_valid/in_ready/in_word carries one word per received packet
// header or timer tick. Output channel out_valid/out_ready/out_word carries the
// result words (ACK, resent request, deliver, done), each with last set on the
// final word caused by one input word. cfg_we/cfg_wdata write timeout_ticks.
// An accepted input word's command is written into the queue at the edge that
// accepts the word; the back end then registers each result word from the queue
// head into the output register. Throughput: the front end takes one input word
// per cycle while the command queue has room; the back end emits one result word
// per cycle while out_ready does not stall it. An in-order data packet produces
// two result words (deliver, ACK), or three with FIN set (deliver, ACK, FIN-ACK).
// Reset clears the mode to receiving, the expected sequence and tick counter to
// zero, timeout_ticks to 1000, and empties the queue and output register.
// When the receiver stalls out_ready, the output word holds, the queue fills,
// and in_ready drops once the queue is full; words that cause no result still
// need in_ready, since they pass through the front end's state update.
`default_nettype none

module cumulative_ack_receiver_core #(
    parameter int MAX_PAYLOAD = car_pkg::CAR_MAX_PAYLOAD,
    parameter int QUEUE_DEPTH = car_pkg::CAR_QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_wdata,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire car_pkg::car_in_t in_word,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output car_pkg::car_out_t     out_word
);
    import car_pkg::*;

    // Commands flow from the front end into the queue and out to the back end.
    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     q_pop;
    car_cmd_t q_push_cmd;
    car_cmd_t q_head;

    car_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (q_push_cmd)
    );

    car_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    car_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire
